@@ design/fifo_reader_writer_lock_arbiter_assert.svh @@
// Assertion macros for the lock arbiter checker.
// Each macro expects signals named clk and rst_n in the calling scope.
`ifndef FIFO_READER_WRITER_LOCK_ARBITER_ASSERT_SVH
`define FIFO_READER_WRITER_LOCK_ARBITER_ASSERT_SVH

// Condition and consequence in the same cycle.
`define FRWL_ASSERT_SAME(label, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

// Consequence in the cycle after the condition.
`define FRWL_ASSERT_NEXT(label, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

@@ design/frwl_pkg.sv @@
`timescale 1ns / 1ps

package frwl_pkg;

    localparam int HOLDER_DEPTH = 16;
    localparam int WAIT_DEPTH   = 16;
    localparam int MAX_RESULTS  = 17;
    localparam int MAX_GRANTS   = MAX_RESULTS - 1;

    localparam int AGENT_W  = 6;
    localparam int STATUS_W = 3;

    localparam int HIDX_W  = (HOLDER_DEPTH > 1) ? $clog2(HOLDER_DEPTH) : 1;
    localparam int HCNT_W  = $clog2(HOLDER_DEPTH + 1);
    localparam int WIDX_W  = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
    localparam int WCNT_W  = $clog2(WAIT_DEPTH + 1);
    localparam int GCNT_W  = $clog2(MAX_GRANTS + 1);

    localparam logic CMD_ACQUIRE = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_GRANTED    = 3'd0,
        ST_QUEUED     = 3'd1,
        ST_RELEASED   = 3'd2,
        ST_FULL       = 3'd3,
        ST_NOT_HOLDER = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACQ,
        S_SCAN,
        S_REPORT,
        S_GRANT
    } state_t;

endpackage

@@ design/frwl_req_if.sv @@
`timescale 1ns / 1ps

interface frwl_req_if
    import frwl_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               cmd;
    logic [AGENT_W-1:0] requester;
    logic               want_write;

    modport source (output valid, cmd, requester, want_write, input ready);
    modport sink   (input valid, cmd, requester, want_write, output ready);
endinterface

@@ design/frwl_rsp_if.sv @@
`timescale 1ns / 1ps

interface frwl_rsp_if
    import frwl_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [AGENT_W-1:0]  agent;
    logic [STATUS_W-1:0] status;
    logic                last;

    modport source (output valid, agent, status, last, input ready);
    modport sink   (input valid, agent, status, last, output ready);
endinterface

@@ design/fifo_reader_writer_lock_arbiter.sv @@
`timescale 1ns / 1ps
// Fair reader-writer lock arbiter with a FIFO of waiting agents.
// req (sink): one transaction per command; cmd 0 acquires (want_write picks
//   shared or exclusive), cmd 1 releases on behalf of requester.
// rsp (source): result transactions; last marks the final one of a command.
//   An acquire yields one result (granted, queued or queue full). A release
//   yields "not holder", or "released" followed by one grant per waiter
//   woken, in queue order.
// Sequencing: an acquire is taken in S_IDLE and its result loaded from S_ACQ
//   once the output register is free. A release walks the holder table one
//   entry a cycle through a single comparator in S_SCAN, up to all 16
//   entries, then loads the released or not-holder result from S_REPORT;
//   each waiter granted passes through S_GRANT and S_REPORT in turn.
// One command is worked at a time; req.ready is high only while the
//   sequencer is idle, though the last result may still sit in the output
//   register waiting for rsp.ready.
// A stalled rsp.ready holds the output register and the sequencer waits.
// Reset (rst_n low, asynchronous) empties the holder table and the queue and
//   sets read mode; the block is ready as soon as reset is released.
module fifo_reader_writer_lock_arbiter
    import frwl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    frwl_req_if.sink    req,
    frwl_rsp_if.source  rsp
);

    // control state
    state_t                  state_reg, state_next;
    logic [HOLDER_DEPTH-1:0] holder_valid_reg;
    logic [HCNT_W-1:0]       holder_count_reg, holder_count_next;
    logic [WIDX_W-1:0]       wait_head_reg, wait_head_next;
    logic [WCNT_W-1:0]       wait_count_reg, wait_count_next;
    logic                    mode_write_reg, mode_write_next;
    logic [HIDX_W-1:0]       scan_idx_reg, scan_idx_next;
    logic [GCNT_W-1:0]       grant_cnt_reg, grant_cnt_next;
    logic                    pend_chain_reg, pend_chain_next;
    logic                    rsp_valid_reg, rsp_valid_next;

    // payload state
    logic [AGENT_W-1:0]      holder_agent_reg [HOLDER_DEPTH];
    logic [AGENT_W-1:0]      waiter_agent_reg [WAIT_DEPTH];
    logic                    waiter_writes_reg [WAIT_DEPTH];
    logic [AGENT_W-1:0]      who_reg;
    logic                    wr_reg;
    logic [AGENT_W-1:0]      pend_agent_reg, pend_agent_next;
    status_t                 pend_status_reg, pend_status_next;
    logic [AGENT_W-1:0]      rsp_agent_reg, rsp_agent_next;
    status_t                 rsp_status_reg, rsp_status_next;
    logic                    rsp_last_reg, rsp_last_next;

    // write strobes for the tables
    logic                    hold_set_en;
    logic [HIDX_W-1:0]       hold_set_idx;
    logic [AGENT_W-1:0]      hold_set_agent;
    logic                    hold_clr_en;
    logic                    wait_push_en;
    logic                    req_take;
    logic                    rsp_load;

    logic                    out_free;
    logic [HIDX_W-1:0]       free_idx;
    logic                    holders_full;
    logic [WCNT_W:0]         tail_sum;
    logic [WIDX_W-1:0]       tail_idx;
    logic                    head_writes;
    logic [AGENT_W-1:0]      head_agent;
    logic                    grant_ok;
    logic                    scan_hit;
    logic                    acq_grant;

    function automatic logic [HIDX_W-1:0] first_free(input logic [HOLDER_DEPTH-1:0] valid);
        logic [HIDX_W-1:0] idx;
        idx = '0;
        for (int i = HOLDER_DEPTH - 1; i >= 0; i--)
        begin
            if (!valid[i])
            begin
                idx = HIDX_W'(i);
            end
        end
        return idx;
    endfunction

    assign req.ready  = (state_reg == S_IDLE);
    assign rsp.valid  = rsp_valid_reg;
    assign rsp.agent  = rsp_agent_reg;
    assign rsp.status = rsp_status_reg;
    assign rsp.last   = rsp_last_reg;

    assign out_free     = !rsp_valid_reg || rsp.ready;
    assign free_idx     = first_free(holder_valid_reg);
    assign holders_full = (holder_count_reg >= HCNT_W'(HOLDER_DEPTH));

    // queue tail, wrapped with one compare and subtract
    always_comb
    begin
        tail_sum = {{(WCNT_W + 1 - WIDX_W){1'b0}}, wait_head_reg} + {1'b0, wait_count_reg};
        if (tail_sum >= (WCNT_W + 1)'(WAIT_DEPTH))
        begin
            tail_sum = tail_sum - (WCNT_W + 1)'(WAIT_DEPTH);
        end
        tail_idx = tail_sum[WIDX_W-1:0];
    end

    assign head_agent  = waiter_agent_reg[wait_head_reg];
    assign head_writes = waiter_writes_reg[wait_head_reg];

    // can the queue head be granted against the current holder state
    assign grant_ok = (wait_count_reg != '0) && (grant_cnt_reg < GCNT_W'(MAX_GRANTS)) &&
                      ((holder_count_reg == '0) ||
                       (!head_writes && !mode_write_reg && !holders_full));

    assign scan_hit = holder_valid_reg[scan_idx_reg] &&
                      (holder_agent_reg[scan_idx_reg] == who_reg);

    assign acq_grant = (wait_count_reg == '0) &&
                       ((holder_count_reg == '0) ||
                        (!wr_reg && !mode_write_reg && !holders_full));

    always_comb
    begin
        state_next        = state_reg;
        holder_count_next = holder_count_reg;
        wait_head_next    = wait_head_reg;
        wait_count_next   = wait_count_reg;
        mode_write_next   = mode_write_reg;
        scan_idx_next     = scan_idx_reg;
        grant_cnt_next    = grant_cnt_reg;
        pend_chain_next   = pend_chain_reg;
        pend_agent_next   = pend_agent_reg;
        pend_status_next  = pend_status_reg;
        rsp_valid_next    = rsp_valid_reg && !rsp.ready;
        rsp_agent_next    = rsp_agent_reg;
        rsp_status_next   = rsp_status_reg;
        rsp_last_next     = rsp_last_reg;
        hold_set_en       = 1'b0;
        hold_set_idx      = free_idx;
        hold_set_agent    = who_reg;
        hold_clr_en       = 1'b0;
        wait_push_en      = 1'b0;
        req_take          = 1'b0;
        rsp_load          = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    req_take       = 1'b1;
                    scan_idx_next  = '0;
                    grant_cnt_next = '0;
                    state_next     = (req.cmd == CMD_RELEASE) ? S_SCAN : S_ACQ;
                end
            end

            S_ACQ:
            begin
                if (out_free)
                begin
                    rsp_load       = 1'b1;
                    rsp_agent_next = who_reg;
                    rsp_last_next  = 1'b1;
                    if (acq_grant)
                    begin
                        if (holder_count_reg == '0)
                        begin
                            mode_write_next = wr_reg;
                        end
                        hold_set_en       = 1'b1;
                        holder_count_next = holder_count_reg + 1'b1;
                        rsp_status_next   = ST_GRANTED;
                    end
                    else if (wait_count_reg >= WCNT_W'(WAIT_DEPTH))
                    begin
                        rsp_status_next = ST_FULL;
                    end
                    else
                    begin
                        wait_push_en    = 1'b1;
                        wait_count_next = wait_count_reg + 1'b1;
                        rsp_status_next = ST_QUEUED;
                    end
                    state_next = S_IDLE;
                end
            end

            S_SCAN:
            begin
                pend_agent_next = who_reg;
                if (scan_hit)
                begin
                    hold_clr_en       = 1'b1;
                    holder_count_next = holder_count_reg - 1'b1;
                    pend_status_next  = ST_RELEASED;
                    pend_chain_next   = 1'b1;
                    state_next        = S_REPORT;
                end
                else if (scan_idx_reg == HIDX_W'(HOLDER_DEPTH - 1))
                begin
                    pend_status_next = ST_NOT_HOLDER;
                    pend_chain_next  = 1'b0;
                    state_next       = S_REPORT;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end

            S_REPORT:
            begin
                if (out_free)
                begin
                    rsp_load        = 1'b1;
                    rsp_agent_next  = pend_agent_reg;
                    rsp_status_next = pend_status_reg;
                    rsp_last_next   = !(pend_chain_reg && grant_ok);
                    state_next      = (pend_chain_reg && grant_ok) ? S_GRANT : S_IDLE;
                end
            end

            S_GRANT:
            begin
                if (holder_count_reg == '0)
                begin
                    mode_write_next = head_writes;
                end
                hold_set_en       = 1'b1;
                hold_set_agent    = head_agent;
                holder_count_next = holder_count_reg + 1'b1;
                wait_head_next    = (wait_head_reg == WIDX_W'(WAIT_DEPTH - 1)) ?
                                    '0 : wait_head_reg + 1'b1;
                wait_count_next   = wait_count_reg - 1'b1;
                grant_cnt_next    = grant_cnt_reg + 1'b1;
                pend_agent_next   = head_agent;
                pend_status_next  = ST_GRANTED;
                pend_chain_next   = 1'b1;
                state_next        = S_REPORT;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            holder_valid_reg <= '0;
            holder_count_reg <= '0;
            wait_head_reg    <= '0;
            wait_count_reg   <= '0;
            mode_write_reg   <= 1'b0;
            scan_idx_reg     <= '0;
            grant_cnt_reg    <= '0;
            pend_chain_reg   <= 1'b0;
            rsp_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            holder_count_reg <= holder_count_next;
            wait_head_reg    <= wait_head_next;
            wait_count_reg   <= wait_count_next;
            mode_write_reg   <= mode_write_next;
            scan_idx_reg     <= scan_idx_next;
            grant_cnt_reg    <= grant_cnt_next;
            pend_chain_reg   <= pend_chain_next;
            rsp_valid_reg    <= rsp_valid_next;
            if (hold_set_en)
            begin
                holder_valid_reg[hold_set_idx] <= 1'b1;
            end
            if (hold_clr_en)
            begin
                holder_valid_reg[scan_idx_reg] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            who_reg <= req.requester;
            wr_reg  <= req.want_write;
        end
        if (hold_set_en)
        begin
            holder_agent_reg[hold_set_idx] <= hold_set_agent;
        end
        if (wait_push_en)
        begin
            waiter_agent_reg[tail_idx]  <= who_reg;
            waiter_writes_reg[tail_idx] <= wr_reg;
        end
        pend_agent_reg  <= pend_agent_next;
        pend_status_reg <= pend_status_next;
        rsp_agent_reg   <= rsp_agent_next;
        rsp_status_reg  <= rsp_status_next;
        rsp_last_reg    <= rsp_last_next;
    end

endmodule

@@ design/frwl_checker.sv @@
`timescale 1ns / 1ps
`include "fifo_reader_writer_lock_arbiter_assert.svh"

module frwl_checker
    import frwl_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_ready,
    input logic                rsp_valid,
    input logic                rsp_ready,
    input logic [STATUS_W-1:0] rsp_status,
    input logic                rsp_last
);

    logic single_result;

    assign single_result = rsp_status inside {ST_QUEUED, ST_FULL, ST_NOT_HOLDER};

    // a command in flight blocks the request side
    `FRWL_ASSERT_NEXT(a_busy_after_take, req_valid && req_ready, !req_ready, "ready after take")

    // a non-final result means grants are still to come
    `FRWL_ASSERT_SAME(a_chain_busy, rsp_valid && !rsp_last, !req_ready, "ready mid-chain")

    // queued, rejected and non-holder results always end their command
    `FRWL_ASSERT_SAME(a_single_final, rsp_valid && single_result, rsp_last, "single not final")

    `FRWL_ASSERT_SAME(a_status_range, rsp_valid, rsp_status <= ST_NOT_HOLDER, "status out of range")

    `FRWL_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "result dropped while stalled")

endmodule

bind fifo_reader_writer_lock_arbiter frwl_checker u_frwl_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_status (rsp.status),
    .rsp_last   (rsp.last)
);
